FILE: rtl/multi_voice_linear_fade_macros.svh
// Assertion macros shared by the checker.
`ifndef MULTI_VOICE_LINEAR_FADE_MACROS_SVH
`define MULTI_VOICE_LINEAR_FADE_MACROS_SVH
// Implication checked every cycle outside reset.
`define MVLF_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication checked outside reset.
`define MVLF_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

FILE: rtl/mvlf_pkg.sv
// Shared types and constants for the multi-voice linear fade block.
`timescale 1ns / 1ps
package mvlf_pkg;
  localparam int VOICE_SLOTS_DEF = 16;
  localparam logic [15:0] LEVEL_ONE = 16'd32768;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic apply;
    logic eval;
    logic div_start;
    logic div_step;
    logic emit;
    logic next_slot;
  } ctrl_t;

  typedef struct packed {
    logic is_tick;
    logic scan_done;
    logic need_div;
    logic div_done;
    logic last_slot;
  } stat_t;
endpackage

FILE: rtl/multi_voice_linear_fade.sv
// Multi-voice linear fade: a table of voice slots with linear Q1.15 ramps.
// Add, remove and start take one word in and give one word out after a
// serial slot search. A tick gives one word per slot in slot order, a
// ramping slot passing through the bit-serial divider first. Output
// stalls hold back the search result and the tick walk. One word is
// worked on at a time.
`timescale 1ns / 1ps
module multi_voice_linear_fade #(
  parameter int VOICE_SLOTS = mvlf_pkg::VOICE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [15:0]        voice_id,
  input  logic [31:0]        now_tick,
  input  logic signed [16:0] target_level,
  input  logic signed [31:0] fade_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         slot,
  output logic [15:0]        slot_voice,
  output logic [15:0]        level,
  output logic               is_fading,
  output logic               ok,
  output logic               last
);
  mvlf_pkg::ctrl_t ctrl;
  mvlf_pkg::stat_t stat;

  mvlf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .ctrl(ctrl)
  );

  mvlf_data #(.VOICE_SLOTS(VOICE_SLOTS)) u_data (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .cmd(cmd), .voice_id(voice_id), .now_tick(now_tick),
    .target_level(target_level), .fade_ticks(fade_ticks),
    .slot(slot), .slot_voice(slot_voice), .level(level),
    .is_fading(is_fading), .ok(ok), .last(last),
    .out_valid(out_valid), .out_stall(out_stall)
  );
endmodule

FILE: rtl/mvlf_ctrl.sv
// Controller state machine sequencing commands, slot walks and division.
`timescale 1ns / 1ps
module mvlf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_valid,
  input  logic             out_stall,
  input  mvlf_pkg::stat_t  stat,
  output mvlf_pkg::ctrl_t  ctrl
);
  mvlf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= mvlf_pkg::ST_IDLE;
    else state <= state_next;
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      mvlf_pkg::ST_IDLE: if (in_valid) state_next = mvlf_pkg::ST_SCAN;
      mvlf_pkg::ST_SCAN: begin
        if (stat.is_tick) state_next = mvlf_pkg::ST_EVAL;
        else if (stat.scan_done && out_free) state_next = mvlf_pkg::ST_EMIT;
      end
      mvlf_pkg::ST_EVAL: state_next = stat.need_div ? mvlf_pkg::ST_DIV : mvlf_pkg::ST_EMIT;
      mvlf_pkg::ST_DIV: if (stat.div_done) state_next = mvlf_pkg::ST_EMIT;
      mvlf_pkg::ST_EMIT: begin
        if (out_free) begin
          if (stat.is_tick && !stat.last_slot) state_next = mvlf_pkg::ST_EVAL;
          else state_next = mvlf_pkg::ST_IDLE;
        end
      end
      default: state_next = mvlf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_stall = 1'b1;
    case (state)
      mvlf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        ctrl.load = in_valid;
      end
      mvlf_pkg::ST_SCAN: begin
        ctrl.scan_step = !stat.is_tick && !stat.scan_done;
        ctrl.apply = !stat.is_tick && stat.scan_done && out_free;
      end
      mvlf_pkg::ST_EVAL: begin
        ctrl.eval = 1'b1;
        ctrl.div_start = stat.need_div;
      end
      mvlf_pkg::ST_DIV: ctrl.div_step = !stat.div_done;
      mvlf_pkg::ST_EMIT: begin
        ctrl.emit = out_free;
        ctrl.next_slot = out_free && stat.is_tick;
      end
      default: ;
    endcase
  end
endmodule

FILE: rtl/mvlf_data.sv
// Datapath: slot tables, slot search, ramp arithmetic, divider, output register.
`timescale 1ns / 1ps
module mvlf_data #(
  parameter int VOICE_SLOTS = mvlf_pkg::VOICE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mvlf_pkg::ctrl_t     ctrl,
  output mvlf_pkg::stat_t     stat,
  input  logic [1:0]          cmd,
  input  logic [15:0]         voice_id,
  input  logic [31:0]         now_tick,
  input  logic signed [16:0]  target_level,
  input  logic signed [31:0]  fade_ticks,
  output logic [5:0]          slot,
  output logic [15:0]         slot_voice,
  output logic [15:0]         level,
  output logic                is_fading,
  output logic                ok,
  output logic                last,
  output logic                out_valid,
  input  logic                out_stall
);
  localparam int SW = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam logic [SW:0] LAST_IDX = (SW + 1)'(VOICE_SLOTS - 1);

  logic [15:0] voice_of_slot [VOICE_SLOTS];
  logic [15:0] start_lvl [VOICE_SLOTS];
  logic [15:0] end_lvl [VOICE_SLOTS];
  logic [30:0] ramp_len [VOICE_SLOTS];
  logic [31:0] start_tick [VOICE_SLOTS];
  logic [15:0] present [VOICE_SLOTS];
  logic        active [VOICE_SLOTS];
  logic [6:0]  used_count;

  logic [1:0]  r_cmd;
  logic [15:0] r_id;
  logic [31:0] r_now;
  logic [15:0] r_tgt;
  logic [30:0] r_len;
  logic [SW:0] idx;
  logic        found;
  logic [SW-1:0] cur;
  assign cur = idx[SW-1:0];

  // signed product diff*el, then restoring division of magnitude
  logic        neg;
  logic [30:0] divisor;
  logic [47:0] quo;
  logic [31:0] acc;
  logic [5:0]  bitn;

  logic [15:0] key;
  assign key = (r_cmd == mvlf_pkg::CMD_ADD) ? 16'd0 : r_id;

  logic [31:0] el_raw, el;
  logic [15:0] eff_end;
  logic        still_act;
  always_comb begin
    el_raw = r_now - start_tick[cur];
    el = el_raw[31] ? 32'd0 : el_raw;
    eff_end = end_lvl[cur];
    still_act = active[cur] && (present[cur] != eff_end);
  end

  logic signed [16:0] diff;
  assign diff = $signed({1'b0, end_lvl[cur]}) - $signed({1'b0, start_lvl[cur]});

  logic occupied;
  assign occupied = voice_of_slot[cur] != 16'd0;

  assign stat.is_tick = (r_cmd == mvlf_pkg::CMD_TICK);
  assign stat.scan_done = found || (idx == LAST_IDX + 1'b1) || (r_id == 16'd0);
  assign stat.need_div = occupied && still_act && (el < {1'b0, ramp_len[cur]});
  assign stat.div_done = (bitn == 6'd0);
  assign stat.last_slot = (idx == LAST_IDX);

  logic [31:0] shifted;
  assign shifted = {acc[30:0], quo[47]};
  logic trial;
  assign trial = shifted >= {1'b0, divisor};

  logic [15:0] ramp_lvl;
  assign ramp_lvl = start_lvl[cur] + (neg ? -quo[15:0] : quo[15:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICE_SLOTS; i++) begin
        voice_of_slot[i] <= '0;
        start_lvl[i] <= '0;
        end_lvl[i] <= '0;
        ramp_len[i] <= '0;
        start_tick[i] <= '0;
        present[i] <= '0;
        active[i] <= 1'b0;
      end
      used_count <= '0;
      out_valid <= 1'b0;
      idx <= '0;
      found <= 1'b0;
      bitn <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (ctrl.load) begin
        r_cmd <= cmd;
        r_id <= voice_id;
        r_now <= now_tick;
        r_tgt <= target_level[16] ? 16'd0 :
                 (target_level > 17'sd32768) ? mvlf_pkg::LEVEL_ONE : target_level[15:0];
        r_len <= fade_ticks[31] ? 31'd0 : fade_ticks[30:0];
        idx <= '0;
        found <= 1'b0;
      end
      if (ctrl.scan_step) begin
        if (voice_of_slot[cur] == key) found <= 1'b1;
        else idx <= idx + 1'b1;
      end
      if (ctrl.apply) begin
        slot <= '0; slot_voice <= '0; level <= '0; is_fading <= 1'b0; ok <= 1'b0;
        last <= 1'b1;
        if (found && r_id != 16'd0) begin
          ok <= 1'b1;
          slot <= 6'(idx);
          level <= present[cur];
          case (r_cmd)
            mvlf_pkg::CMD_ADD: begin
              voice_of_slot[cur] <= r_id;
              slot_voice <= r_id;
              is_fading <= active[cur];
              if (used_count < 7'(VOICE_SLOTS)) used_count <= used_count + 1'b1;
            end
            mvlf_pkg::CMD_REMOVE: begin
              voice_of_slot[cur] <= '0;
              slot_voice <= '0;
              is_fading <= active[cur];
              if (used_count != 0) used_count <= used_count - 1'b1;
            end
            default: begin
              start_lvl[cur] <= present[cur];
              end_lvl[cur] <= r_tgt;
              ramp_len[cur] <= r_len;
              start_tick[cur] <= r_now;
              active[cur] <= 1'b1;
              slot_voice <= voice_of_slot[cur];
              is_fading <= 1'b1;
            end
          endcase
        end
      end
      if (ctrl.eval) begin
        if (occupied) begin
          if (!still_act) active[cur] <= 1'b0;
          else if (el >= {1'b0, ramp_len[cur]}) begin
            present[cur] <= end_lvl[cur];
            ramp_len[cur] <= '0;
            active[cur] <= 1'b0;
          end
        end
        neg <= diff[16];
        quo <= {1'b0, 47'(diff[16] ? 17'(-diff) : diff) * 47'(el[30:0])};
        acc <= '0;
        divisor <= ramp_len[cur];
        bitn <= 6'd48;
      end
      if (ctrl.div_step) begin
        quo <= {quo[46:0], trial};
        acc <= trial ? shifted - {1'b0, divisor} : shifted;
        bitn <= bitn - 1'b1;
      end
      if (ctrl.emit) begin
        out_valid <= 1'b1;
        if (stat.is_tick) begin
          slot <= 6'(idx);
          slot_voice <= voice_of_slot[cur];
          is_fading <= active[cur];
          ok <= occupied;
          last <= (idx == LAST_IDX);
          if (bitn == 6'd0 && divisor != '0 && active[cur]) begin
            level <= ramp_lvl;
            present[cur] <= ramp_lvl;
          end else begin
            level <= present[cur];
          end
        end
        divisor <= '0;
      end
      if (ctrl.next_slot) idx <= idx + 1'b1;
    end
  end
endmodule

FILE: rtl/mvlf_checker.sv
// Port-level checker for the multi-voice linear fade block, with its bind.
`timescale 1ns / 1ps
`include "multi_voice_linear_fade_macros.svh"
module mvlf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] level,
  input logic        ok,
  input logic [15:0] slot_voice,
  input logic        is_fading
);
  `MVLF_ASSERT_IMP(a_level_range, clk, rst, out_valid, level <= 16'd32768)
  `MVLF_ASSERT_NXT(a_level_hold, clk, rst, out_valid && out_stall, $stable(level))
  `MVLF_ASSERT_IMP(a_fail_clean, clk, rst, out_valid && !ok, !is_fading || slot_voice == 16'd0)
  `MVLF_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
endmodule

bind multi_voice_linear_fade mvlf_checker u_chk (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_stall(out_stall), .level(level), .ok(ok),
  .slot_voice(slot_voice), .is_fading(is_fading)
);

FILE: tb/sv/tb_multi_voice_linear_fade.sv
// Testbench for multi_voice_linear_fade: queued driver, self-predicting monitor.
`timescale 1ns / 1ps
module tb_multi_voice_linear_fade;
  localparam int NSLOT = mvlf_pkg::VOICE_SLOTS_DEF;
  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    logic [1:0]         cmd;
    logic [15:0]        id;
    logic [31:0]        now;
    logic signed [16:0] tgt;
    logic signed [31:0] fade;
    bit                 hold;
  } cmd_word_t;

  typedef struct {
    logic [5:0]  slot;
    logic [15:0] voice;
    logic [15:0] level;
    logic        fading;
    logic        ok;
    logic        last;
  } slot_word_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] cmd;
  logic [15:0] voice_id;
  logic [31:0] now_tick;
  logic signed [16:0] target_level;
  logic signed [31:0] fade_ticks;
  logic [5:0] slot;
  logic [15:0] slot_voice, level;
  logic is_fading, ok, last;

  multi_voice_linear_fade dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .voice_id(voice_id), .now_tick(now_tick),
    .target_level(target_level), .fade_ticks(fade_ticks),
    .out_valid(out_valid), .out_stall(out_stall),
    .slot(slot), .slot_voice(slot_voice), .level(level),
    .is_fading(is_fading), .ok(ok), .last(last)
  );

  cmd_word_t  pending_cmds[$];
  slot_word_t expected_slots[$];

  logic [15:0] m_voice[NSLOT];
  logic [15:0] m_start_lvl[NSLOT];
  logic [15:0] m_end_lvl[NSLOT];
  logic [31:0] m_len[NSLOT];
  logic [31:0] m_start_tick[NSLOT];
  logic [15:0] m_level[NSLOT];
  bit          m_active[NSLOT];

  bit fail_seen;
  bit quiet;
  bit in_took, out_took;
  int unsigned in_gap, out_gap, idle_cycles;
  logic [31:0] clock_now;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic void push_slot(int s, bit okv, bit lastv);
    slot_word_t w;
    w.slot = s[5:0];
    w.voice = m_voice[s];
    w.level = m_level[s];
    w.fading = m_active[s];
    w.ok = okv;
    w.last = lastv;
    expected_slots.push_back(w);
  endfunction

  function automatic void push_reject();
    slot_word_t w;
    w = '{6'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1};
    expected_slots.push_back(w);
  endfunction

  function automatic int lowest_slot(logic [15:0] id);
    for (int i = 0; i < NSLOT; i++)
      if (m_voice[i] == id) return i;
    return -1;
  endfunction

  function automatic void advance_ramp(int i, logic [31:0] now);
    logic [31:0] el, len;
    longint diff, q;
    if (m_voice[i] == 0) return;
    if (m_level[i] == m_end_lvl[i]) m_active[i] = 0;
    if (!m_active[i]) return;
    el = now - m_start_tick[i];
    if (el[31]) el = 0;
    len = {1'b0, m_len[i][30:0]};
    if (el >= len) begin
      m_level[i] = m_end_lvl[i];
      m_len[i] = 0;
      m_active[i] = 0;
      return;
    end
    diff = longint'(m_end_lvl[i]) - longint'(m_start_lvl[i]);
    q = (diff * longint'(el)) / longint'(len);
    m_level[i] = 16'(longint'(m_start_lvl[i]) + q);
  endfunction

  function automatic void predict_fade(cmd_word_t c);
    int s;
    int t;
    if (c.cmd == mvlf_pkg::CMD_TICK) begin
      for (int i = 0; i < NSLOT; i++) begin
        advance_ramp(i, c.now);
        push_slot(i, m_voice[i] != 0, i == NSLOT - 1);
      end
      return;
    end
    if (c.id == 0) begin
      push_reject();
      return;
    end
    s = lowest_slot(c.cmd == mvlf_pkg::CMD_ADD ? 16'd0 : c.id);
    if (s < 0) begin
      push_reject();
      return;
    end
    case (c.cmd)
      mvlf_pkg::CMD_ADD: m_voice[s] = c.id;
      mvlf_pkg::CMD_REMOVE: m_voice[s] = 0;
      default: begin
        t = c.tgt;
        if (t < 0) t = 0;
        if (t > mvlf_pkg::LEVEL_ONE) t = mvlf_pkg::LEVEL_ONE;
        m_start_lvl[s] = m_level[s];
        m_end_lvl[s] = t[15:0];
        m_len[s] = c.fade[31] ? 32'd0 : c.fade;
        m_start_tick[s] = c.now;
        m_active[s] = 1;
      end
    endcase
    push_slot(s, 1, 1);
  endfunction

  // monitor, predictor feed and watchdog
  always @(posedge clk) begin
    slot_word_t e;
    cmd_word_t c;
    in_took <= !rst && in_valid && !in_stall;
    out_took <= !rst && out_valid && !out_stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_slots.size() == 0) begin
          $display("%0t: unexpected word slot=%0d voice=%0d level=%0d", $realtime,
                   slot, slot_voice, level);
          fail_seen = 1;
        end else begin
          e = expected_slots.pop_front();
          if (slot !== e.slot || slot_voice !== e.voice || level !== e.level ||
              is_fading !== e.fading || ok !== e.ok || last !== e.last) begin
            $display("%0t: mismatch exp slot=%0d voice=%0d level=%0d fading=%0b ok=%0b last=%0b",
                     $realtime, e.slot, e.voice, e.level, e.fading, e.ok, e.last);
            $display("%0t:          got slot=%0d voice=%0d level=%0d fading=%0b ok=%0b last=%0b",
                     $realtime, slot, slot_voice, level, is_fading, ok, last);
            fail_seen = 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        c.cmd = cmd; c.id = voice_id; c.now = now_tick;
        c.tgt = target_level; c.fade = fade_ticks; c.hold = 0;
        predict_fade(c);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("%0t: watchdog timeout", $realtime);
        $display("tb_multi_voice_linear_fade: FAIL");
        $finish;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    cmd_word_t c;
    if (rst) begin
      in_valid = 0;
      out_stall = 0;
    end else begin
      if (in_took) begin
        in_valid = 0;
        in_gap = quiet ? 0 : $urandom_range(0, 12);
      end
      if (!in_valid) begin
        if (in_gap > 0) in_gap--;
        else if (pending_cmds.size() > 0 &&
                 !(pending_cmds[0].hold && expected_slots.size() != 0)) begin
          c = pending_cmds.pop_front();
          cmd = c.cmd; voice_id = c.id; now_tick = c.now;
          target_level = c.tgt; fade_ticks = c.fade;
          in_valid = 1;
        end
      end
      if (out_took) out_gap = quiet ? 0 : $urandom_range(0, 12);
      else if (out_gap > 0) out_gap--;
      out_stall = (out_gap != 0);
    end
  end

  task automatic queue_cmd(logic [1:0] k, logic [15:0] id, logic [31:0] now,
                           logic signed [16:0] tgt, logic signed [31:0] fade,
                           bit hold = 0);
    cmd_word_t c;
    c.cmd = k; c.id = id; c.now = now; c.tgt = tgt; c.fade = fade; c.hold = hold;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [15:0] pick_voice();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
  endfunction

  initial begin
    int k;
    logic signed [16:0] tg;
    logic signed [31:0] fd;
    rst = 1;
    in_valid = 0; out_stall = 0;
    cmd = mvlf_pkg::CMD_TICK; voice_id = 0; now_tick = 0; target_level = 0; fade_ticks = 0;
    fail_seen = 0; quiet = 0; in_gap = 0; out_gap = 0; idle_cycles = 0;
    clock_now = 0;
    for (int i = 0; i < NSLOT; i++) begin
      m_voice[i] = 0; m_start_lvl[i] = 0; m_end_lvl[i] = 0; m_len[i] = 0;
      m_start_tick[i] = 0; m_level[i] = 0; m_active[i] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed
    queue_cmd(mvlf_pkg::CMD_TICK, 0, 0, 0, 0);
    queue_cmd(mvlf_pkg::CMD_ADD, 0, 0, 0, 0);
    queue_cmd(mvlf_pkg::CMD_REMOVE, 5, 0, 0, 0);
    queue_cmd(mvlf_pkg::CMD_START, 5, 0, 0, 0);
    queue_cmd(mvlf_pkg::CMD_ADD, 16'hFFFF, 0, 0, 0);
    queue_cmd(mvlf_pkg::CMD_ADD, 1, 0, 0, 0);
    queue_cmd(mvlf_pkg::CMD_ADD, 1, 0, 0, 0);
    queue_cmd(mvlf_pkg::CMD_START, 16'hFFFF, 32'hFFFF_FFF0, 17'sd65535, 32'sd2147483647);
    queue_cmd(mvlf_pkg::CMD_START, 1, 100, 17'sh10000, -32'sd1);
    queue_cmd(mvlf_pkg::CMD_START, 0, 0, 0, 0);
    queue_cmd(mvlf_pkg::CMD_TICK, 0, 32'h8000_0000, 0, 0);
    queue_cmd(mvlf_pkg::CMD_START, 1, 200, 17'sd32768, 32'sh8000_0000);
    queue_cmd(mvlf_pkg::CMD_TICK, 0, 199, 0, 0);
    queue_cmd(mvlf_pkg::CMD_TICK, 0, 32'h7FFF_FFF0, 0, 0);
    queue_cmd(mvlf_pkg::CMD_REMOVE, 1, 0, 0, 0);
    queue_cmd(mvlf_pkg::CMD_ADD, 2, 0, 0, 0);
    for (int i = 0; i < NSLOT - 2; i++) queue_cmd(mvlf_pkg::CMD_ADD, 16'(100 + i), 0, 0, 0);
    queue_cmd(mvlf_pkg::CMD_ADD, 7, 0, 0, 0);
    queue_cmd(mvlf_pkg::CMD_TICK, 0, 32'hFFFF_FFFF, 0, 0, 1);

    // random
    for (int n = 0; n < 377; n++) begin
      if (n == 200) queue_cmd(mvlf_pkg::CMD_TICK, 16'(clock_now), clock_now, 0, 0, 1);
      k = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
        tg = 17'($urandom);
        fd = $urandom;
      end else begin
        tg = 17'($urandom_range(0, mvlf_pkg::LEVEL_ONE));
        fd = 32'($urandom_range(0, 60));
      end
      if (k < 40) begin
        clock_now += $urandom_range(0, 10);
        queue_cmd(mvlf_pkg::CMD_TICK, pick_voice(),
                  ($urandom_range(0, 15) == 0) ? 32'($urandom) : clock_now, tg, fd);
      end else if (k < 65) begin
        queue_cmd(mvlf_pkg::CMD_START, pick_voice(),
                  ($urandom_range(0, 15) == 0) ? 32'($urandom) : clock_now, tg, fd);
      end else if (k < 85) begin
        queue_cmd(mvlf_pkg::CMD_ADD, pick_voice(), 32'($urandom), tg, fd);
      end else begin
        queue_cmd(mvlf_pkg::CMD_REMOVE, pick_voice(), 32'($urandom), tg, fd);
      end
    end

    while (pending_cmds.size() != 0 || in_valid || expected_slots.size() != 0) begin
      @(posedge clk);
      if (($urandom_range(0, 299)) == 0) quiet = ~quiet;
    end
    repeat (1000) @(posedge clk);
    if (!fail_seen && expected_slots.size() == 0)
      $display("tb_multi_voice_linear_fade: PASS");
    else
      $display("tb_multi_voice_linear_fade: FAIL");
    $finish;
  end
endmodule
